[rtl/ksfl_pkg.sv]
package ksfl_pkg;

  localparam int NUM_STACKS_DEF = 4;
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int SID_W    = 2;
  localparam int PV_W     = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_DEPTH = 2'd3
  } kind_t;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH
  } state_t;

endpackage

[rtl/ksfl_link_store.sv]
module ksfl_link_store #(
  parameter int CAPACITY = ksfl_pkg::CAPACITY_DEF,
  parameter int LINK_W   = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [LINK_W-1:0] rd_addr,
  output logic [LINK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [LINK_W-1:0] wr_addr,
  input  logic [LINK_W-1:0] wr_data
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic [LINK_W-1:0] mem [CAPACITY];
  logic [LINK_W-1:0] mem_q;
  logic [LINK_W-1:0] addr_q;
  logic              fresh_q;
  logic [LINK_W-1:0] fill;

  // entries at or above the fill mark still hold their reset chain i -> i+1
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && wr_addr >= fill) begin
      fill <= wr_addr + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr[IDX_W-1:0]];
      addr_q  <= rd_addr;
      fresh_q <= (rd_addr >= fill);
    end
  end

  assign rd_data = fresh_q ? (addr_q + LINK_W'(1)) : mem_q;

endmodule

[rtl/k_stacks_shared_free_list_unit.sv]
// channel | beat moves                          | handshake
// --------+-------------------------------------+---------------------------
// in      | kind, stack_id, push_value          | in_valid / in_stall
// out     | status, read_value, depth, store_full | out_valid / out_stall
//
// Every item first reads the stack table; pop and peek of a non-empty stack
// then read the link and value memories at the head.
// One item at a time; in_stall is low only when the unit is idle.
// A finished beat waits in the output register; the unit holds its commit
// while that register is full and stalled.
// Reset needs no clearing pass: a fill mark stands in for the link chain.
module k_stacks_shared_free_list_unit #(
  parameter int NUM_STACKS = ksfl_pkg::NUM_STACKS_DEF,
  parameter int CAPACITY   = ksfl_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ksfl_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [ksfl_pkg::KIND_W-1:0]   kind,
  input  logic        [ksfl_pkg::SID_W-1:0]    stack_id,
  input  logic signed [ksfl_pkg::PV_W-1:0]     push_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [ksfl_pkg::STATUS_W-1:0] status,
  output logic signed [ksfl_pkg::PV_W-1:0]     read_value,
  output logic        [ksfl_pkg::DEPTH_W-1:0]  depth,
  output logic                                 store_full
);

  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  ksfl_pkg::state_t state, state_next;

  ksfl_pkg::kind_t         kind_q;
  logic [SIDX_W-1:0]       sidx_q;
  logic                    present_q;
  logic [VALUE_BITS-1:0]   pv_q;

  logic [2*LINK_W-1:0]     stk_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0]   stk_vld;
  logic [2*LINK_W-1:0]     stk_q;
  logic                    stk_vld_q;

  logic [VALUE_BITS-1:0]   vmem [CAPACITY];
  logic [VALUE_BITS-1:0]   val_q;

  logic [LINK_W-1:0]       free_head, free_head_next;

  logic                    accept, out_free, commit, to_fetch;
  logic [SIDX_W-1:0]       sidx_in;
  logic                    present_in;
  logic signed [63:0]      pv_wide;
  logic [LINK_W-1:0]       head_cur, cnt_cur, link_norm;
  logic                    fh_null, head_null;
  logic signed [VALUE_BITS-1:0] val_s;

  logic                    link_rd_en, link_wr_en;
  logic [LINK_W-1:0]       link_rd_addr, link_rd_data, link_wr_addr, link_wr_data;
  logic                    val_rd_en, val_wr_en, stk_wr_en;
  logic [2*LINK_W-1:0]     stk_wr_data;
  logic [ksfl_pkg::STATUS_W-1:0] res_status;
  logic [ksfl_pkg::PV_W-1:0]     res_value;
  logic [LINK_W-1:0]       res_cnt;

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign sidx_in    = SIDX_W'(stack_id);
  assign present_in = 32'(stack_id) < 32'(NUM_STACKS);
  assign pv_wide    = 64'(push_value);
  assign head_cur   = stk_vld_q ? stk_q[2*LINK_W-1:LINK_W] : NULL_LINK;
  assign cnt_cur    = stk_vld_q ? stk_q[LINK_W-1:0] : '0;
  assign fh_null    = free_head >= NULL_LINK;
  assign head_null  = head_cur >= NULL_LINK;
  assign link_norm  = (link_rd_data >= NULL_LINK) ? NULL_LINK : link_rd_data;
  assign val_s      = val_q;
  assign in_stall   = (state != ksfl_pkg::S_IDLE);

  ksfl_link_store #(
    .CAPACITY (CAPACITY),
    .LINK_W   (LINK_W)
  ) u_links (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ksfl_pkg::S_IDLE: begin
        if (in_valid) state_next = ksfl_pkg::S_LOOKUP;
      end
      ksfl_pkg::S_LOOKUP: begin
        if (to_fetch) state_next = ksfl_pkg::S_FETCH;
        else if (commit) state_next = ksfl_pkg::S_IDLE;
      end
      ksfl_pkg::S_FETCH: begin
        if (commit) state_next = ksfl_pkg::S_IDLE;
      end
      default: state_next = ksfl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    link_rd_en     = 1'b0;
    link_rd_addr   = free_head;
    link_wr_en     = 1'b0;
    link_wr_addr   = free_head;
    link_wr_data   = head_cur;
    val_rd_en      = 1'b0;
    val_wr_en      = 1'b0;
    stk_wr_en      = 1'b0;
    stk_wr_data    = {head_cur, cnt_cur};
    free_head_next = free_head;
    commit         = 1'b0;
    to_fetch       = 1'b0;
    res_status     = ksfl_pkg::STATUS_OK;
    res_value      = '0;
    res_cnt        = cnt_cur;
    unique case (state)
      ksfl_pkg::S_IDLE: begin
        link_rd_en = in_valid && !fh_null;
      end
      ksfl_pkg::S_LOOKUP: begin
        unique case (kind_q)
          ksfl_pkg::KIND_PUSH: begin
            commit = out_free;
            if (!present_q || fh_null) begin
              res_status = ksfl_pkg::STATUS_OVERFLOW;
            end else begin
              res_cnt      = cnt_cur + LINK_W'(1);
              link_wr_en   = out_free;
              link_wr_addr = free_head;
              link_wr_data = head_cur;
              val_wr_en    = out_free;
              stk_wr_en    = out_free;
              stk_wr_data  = {free_head, cnt_cur + LINK_W'(1)};
              if (out_free) free_head_next = link_norm;
            end
          end
          ksfl_pkg::KIND_POP, ksfl_pkg::KIND_PEEK: begin
            if (!present_q || head_null) begin
              commit     = out_free;
              res_status = ksfl_pkg::STATUS_EMPTY;
            end else begin
              link_rd_en   = 1'b1;
              link_rd_addr = head_cur;
              val_rd_en    = 1'b1;
              to_fetch     = 1'b1;
            end
          end
          ksfl_pkg::KIND_DEPTH: begin
            commit = out_free;
          end
          default: commit = out_free;
        endcase
      end
      ksfl_pkg::S_FETCH: begin
        commit    = out_free;
        res_value = ksfl_pkg::PV_W'(val_s);
        if (kind_q == ksfl_pkg::KIND_POP) begin
          res_cnt      = (cnt_cur != '0) ? cnt_cur - LINK_W'(1) : cnt_cur;
          link_wr_en   = out_free;
          link_wr_addr = head_cur;
          link_wr_data = free_head;
          stk_wr_en    = out_free;
          stk_wr_data  = {link_norm, res_cnt};
          if (out_free) free_head_next = head_cur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ksfl_pkg::S_IDLE;
      free_head <= '0;
      stk_vld   <= '0;
      stk_vld_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      if (accept) stk_vld_q <= stk_vld[sidx_in];
      if (stk_wr_en) stk_vld[sidx_q] <= 1'b1;
      if (commit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= ksfl_pkg::kind_t'(kind);
      sidx_q    <= sidx_in;
      present_q <= present_in;
      pv_q      <= pv_wide[VALUE_BITS-1:0];
      stk_q     <= stk_mem[sidx_in];
    end
    if (stk_wr_en) stk_mem[sidx_q] <= stk_wr_data;
  end

  always_ff @(posedge clk) begin
    if (val_wr_en) vmem[free_head[IDX_W-1:0]] <= pv_q;
    if (val_rd_en) val_q <= vmem[head_cur[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status     <= res_status;
      read_value <= res_value;
      depth      <= present_q ? ksfl_pkg::DEPTH_W'(res_cnt) : '0;
      store_full <= (free_head_next >= NULL_LINK);
    end
  end

endmodule

[rtl/ksfl_checker.sv]
module ksfl_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic        [ksfl_pkg::KIND_W-1:0]   kind,
  input logic        [ksfl_pkg::SID_W-1:0]    stack_id,
  input logic signed [ksfl_pkg::PV_W-1:0]     push_value,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic        [ksfl_pkg::STATUS_W-1:0] status,
  input logic signed [ksfl_pkg::PV_W-1:0]     read_value,
  input logic        [ksfl_pkg::DEPTH_W-1:0]  depth,
  input logic                                 store_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value)
      && $stable(depth) && $stable(store_full))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat taken while an item is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ksfl_pkg::STATUS_OK || status == ksfl_pkg::STATUS_OVERFLOW
      || status == ksfl_pkg::STATUS_EMPTY)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ksfl_pkg::STATUS_OK |-> read_value == '0)
    else $error("failed operation returned a value");

endmodule

bind k_stacks_shared_free_list_unit ksfl_checker u_ksfl_checker (.*);
